// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, types and codes of the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CAP_W-1:0]        cap_t;

  localparam val_t MISS_VALUE = '1;

  // lookup result from the directory
  typedef struct packed {
    logic hit;
    idx_t slot;
  } look_t;

  // update command to the directory
  typedef struct packed {
    logic touch;
    logic insert;
    idx_t slot;
    key_t key;
    cnt_t cap;
  } upd_t;

  // capacity register saturated to the number of slots
  function automatic cnt_t sat_cap(cap_t c);
    cnt_t r;
    if (int'(c) > ENTRIES) r = CNT_W'(ENTRIES);
    else r = CNT_W'(c);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lkvc_req_if.sv
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: valid/ready with mode, key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if;
  import lkvc_pkg::*;

  logic valid;
  logic ready;
  logic mode;
  key_t key;
  val_t value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/lkvc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: valid/ready with hit flag and read value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic valid;
  logic ready;
  logic hit;
  val_t read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request beat is a get (mode 0) or a set (mode 1) and yields exactly one
// response beat: hit tells whether the key was present, read_value carries the
// stored value on a get hit and -1 otherwise. Keys, valid bits and recency
// ranks sit in flops for a parallel compare; values sit in a RAM with a
// registered read. An item takes two steps: a lookup state (key compare and
// value RAM read) and an update state (ranks, eviction, tag and RAM write);
// the next request is taken on the update edge and no sooner. A full response
// register lets one item wait in the update state until the response is
// taken. capacity_in_use (saturated to the slot count) is to be written
// through cfg_we_i/cfg_wdata_i while no item is active; the block does not
// enforce this. Zero makes sets do nothing. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  lkvc_pkg::cap_t cfg_wdata_i,
  lkvc_req_if.sink             req_i,
  lkvc_rsp_if.source           rsp_o
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_e;

  state_e state_q;
  cap_t   cap_q;
  logic   mode_q;
  key_t   key_q;
  val_t   value_q;
  logic   hit_q;
  idx_t   slot_q;
  logic   out_valid_q;
  logic   out_hit_q;
  val_t   out_value_q;

  look_t  look;
  upd_t   upd;
  idx_t   ins_slot;
  cnt_t   cap_eff;
  val_t   ram_rdata;
  logic   out_free;
  logic   upd_fire;
  logic   accept;
  logic   set_on;
  logic   ram_we;
  idx_t   ram_waddr;

  assign cap_eff  = sat_cap(cap_q);
  assign set_on   = (mode_q == MODE_SET) && (cap_eff != '0);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign upd_fire = (state_q == S_UPD) && out_free;
  assign req_i.ready = (state_q == S_IDLE) || upd_fire;
  assign accept   = req_i.valid && req_i.ready;

  assign upd.touch  = upd_fire && hit_q && ((mode_q == MODE_GET) || set_on);
  assign upd.insert = upd_fire && !hit_q && set_on;
  assign upd.slot   = slot_q;
  assign upd.key    = key_q;
  assign upd.cap    = cap_eff;

  lkvc_dir u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .look_key_i (key_q),
    .look_o     (look),
    .upd_i      (upd),
    .ins_slot_o (ins_slot)
  );

  // RAM writes land on the update edge and the next lookup reads in the
  // following cycle, so a read never overlaps a write to the same slot
  assign ram_we    = upd_fire && set_on;
  assign ram_waddr = hit_q ? slot_q : ins_slot;

  lkvc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (state_q == S_LOOK),
    .raddr_i (look.slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(16);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_GET;
      key_q       <= '0;
      value_q     <= '0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_value_q <= '0;
    end else begin
      if (rsp_o.ready && !upd_fire) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        mode_q  <= req_i.mode;
        key_q   <= req_i.key;
        value_q <= req_i.value;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q   <= look.hit;
          slot_q  <= look.slot;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (upd_fire) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_value_q <= (hit_q && (mode_q == MODE_GET)) ? ram_rdata : MISS_VALUE;
            state_q     <= accept ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.read_value = out_value_q;

endmodule

`default_nettype wire

// File: hdl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                           wdata_i,
  input  wire                                        re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/lkvc_dir.sv
// ----------------------------------------------------------------------------
// lkvc_dir
// Cache directory: key tags, valid bits, recency ranks and occupancy.
// Parallel key compare, touch and insert-with-eviction updates.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_dir (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  lkvc_pkg::key_t    look_key_i,
  output lkvc_pkg::look_t   look_o,
  input  lkvc_pkg::upd_t    upd_i,
  output lkvc_pkg::idx_t    ins_slot_o
);
  import lkvc_pkg::*;

  key_t               keys_q  [ENTRIES];
  idx_t               rank_q  [ENTRIES];
  idx_t               rank_d  [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  cnt_t               occ_q, occ_d;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] evict;
  logic [ENTRIES-1:0] keep;
  logic               full;
  cnt_t               cap_m1;
  idx_t               touch_rank;

  // parallel compare; keys are unique among valid slots
  always_comb begin
    look_o.hit  = 1'b0;
    look_o.slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (keys_q[i] == look_key_i);
      if (match[i]) begin
        look_o.hit  = 1'b1;
        look_o.slot = IDX_W'(i);
      end
    end
  end

  // ranks of valid slots form 0..occ-1, so repeated eviction of the oldest
  // is the same as dropping every rank at or above cap-1
  assign full   = (occ_q >= upd_i.cap);
  assign cap_m1 = upd_i.cap - CNT_W'(1);

  always_comb begin
    ins_slot_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      evict[i] = full && valid_q[i] && (CNT_W'(rank_q[i]) >= cap_m1);
      keep[i]  = valid_q[i] && !evict[i];
      if (!keep[i]) begin
        ins_slot_o = IDX_W'(i);
      end
    end
  end

  assign touch_rank = rank_q[upd_i.slot];

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    if (upd_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < touch_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[upd_i.slot] = '0;
    end else if (upd_i.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (keep[i]) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      valid_d             = keep;
      valid_d[ins_slot_o] = 1'b1;
      rank_d[ins_slot_o]  = '0;
      occ_d               = (full ? cap_m1 : occ_q) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.insert) begin
      keys_q[ins_slot_o] <= upd_i.key;
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy count out of step with valid bits");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key present in more than one slot");

  a_insert_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.insert |=> valid_q[$past(ins_slot_o)] && (rank_q[$past(ins_slot_o)] == '0))
    else $error("inserted slot not valid and most recent");

  a_touch_on_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.touch |-> valid_q[upd_i.slot])
    else $error("touch of an invalid slot");

endmodule

`default_nettype wire
